// File: rtl/mbe_pkg.sv
// mbe_pkg: shared types, constants and saturating fixed point helpers
// for the escape time engine; no dependencies
package mbe_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int ITER_BITS  = 16;
    localparam int FRAC_BITS  = 28;
    localparam int COEF_BITS  = 32;
    localparam int NORM_BITS  = 63;

    localparam int EXTRA_STEPS = 4;
    localparam int EXTRA_BITS  = $clog2(EXTRA_STEPS);

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_X   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_X  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_Y   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_Y  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ESC_LIMIT = 3'd5;

    localparam logic signed [COEF_BITS-1:0] RST_SCALE_X  = 32'sd1048576;
    localparam logic signed [COEF_BITS-1:0] RST_OFFSET_X = -32'sd536870912;
    localparam logic signed [COEF_BITS-1:0] RST_SCALE_Y  = -32'sd1048576;
    localparam logic signed [COEF_BITS-1:0] RST_OFFSET_Y = 32'sd536870912;
    localparam logic [ITER_BITS-1:0]        RST_MAX_ITER = 16'd100;
    localparam logic [COEF_BITS-1:0]        RST_ESC_LIM  = 32'd1073741824;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [ITER_BITS-1:0] iteration_count;
        logic [NORM_BITS-1:0] final_norm;
    } t_esc_out;

    typedef struct packed {
        logic start;
        logic raw;
    } t_mul_req;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (s < -65'(SAT_MAX)) begin
            return -SAT_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] fx_sign(input logic [NORM_BITS-1:0] m,
                                                  input logic neg);
        logic signed [63:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

endpackage

// File: rtl/mandelbrot_escape_time.sv
// mandelbrot_escape_time: escape time engine for one pixel at a time
// one pixel in flight; the next is accepted once its result is registered and the sequencer is idle again
// every 64-bit product is accumulated from 32x32 partial products on the single shared multiplier
// a loop step takes four products, the four extra steps two each plus a final norm
// synchronous active-low reset restores register defaults and idles the sequencer
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mbe_pkg::t_pix_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mbe_pkg::t_esc_out                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CX, S_CY, S_CHECK, S_M1, S_M2, S_N1, S_N2, S_DONE
    } t_state;

    t_state r_state;

    logic signed [31:0] r_scale_x;
    logic signed [31:0] r_offset_x;
    logic signed [31:0] r_scale_y;
    logic signed [31:0] r_offset_y;
    logic [mbe_pkg::ITER_BITS-1:0] r_max_iter;
    logic [31:0]        r_esc_limit;

    mbe_pkg::t_pix_in   r_pix;
    logic signed [63:0] r_cr;
    logic signed [63:0] r_ci;
    logic signed [63:0] r_zr;
    logic signed [63:0] r_zi;
    logic signed [63:0] r_t;
    logic [mbe_pkg::NORM_BITS-1:0] r_p;
    logic [mbe_pkg::NORM_BITS-1:0] r_norm;
    logic [mbe_pkg::ITER_BITS-1:0] r_count;
    logic               r_extra_phase;
    logic [mbe_pkg::EXTRA_BITS-1:0] r_extra;
    logic               r_wait;
    logic               r_out_valid;
    mbe_pkg::t_esc_out  r_out_data;

    mbe_pkg::t_mul_req  w_req;
    logic [63:0]        w_a;
    logic [63:0]        w_b;
    logic               w_mul_done;
    logic [mbe_pkg::NORM_BITS-1:0] w_mul_res;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_prod;
    logic [63:0]        w_nsum;
    logic               w_accept;
    logic               w_loop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x   <= mbe_pkg::RST_SCALE_X;
            r_offset_x  <= mbe_pkg::RST_OFFSET_X;
            r_scale_y   <= mbe_pkg::RST_SCALE_Y;
            r_offset_y  <= mbe_pkg::RST_OFFSET_Y;
            r_max_iter  <= mbe_pkg::RST_MAX_ITER;
            r_esc_limit <= mbe_pkg::RST_ESC_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbe_pkg::CFG_SCALE_X:   r_scale_x   <= $signed(i_cfg_data);
                mbe_pkg::CFG_OFFSET_X:  r_offset_x  <= $signed(i_cfg_data);
                mbe_pkg::CFG_SCALE_Y:   r_scale_y   <= $signed(i_cfg_data);
                mbe_pkg::CFG_OFFSET_Y:  r_offset_y  <= $signed(i_cfg_data);
                mbe_pkg::CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[mbe_pkg::ITER_BITS-1:0];
                mbe_pkg::CFG_ESC_LIMIT: r_esc_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier
    assign w_sum  = mbe_pkg::sat_add(r_zr, r_zi);
    assign w_diff = mbe_pkg::sat_add(r_zr, -r_zi);

    always_comb begin
        w_req.start = 1'b0;
        w_req.raw   = 1'b0;
        w_a         = '0;
        w_b         = '0;
        unique case (r_state)
            S_CX: begin
                w_req.start = !r_wait;
                w_req.raw   = 1'b1;
                w_a = mbe_pkg::mag64(64'(r_scale_x));
                w_b = 64'(r_pix.pixel_x);
            end
            S_CY: begin
                w_req.start = !r_wait;
                w_req.raw   = 1'b1;
                w_a = mbe_pkg::mag64(64'(r_scale_y));
                w_b = 64'(r_pix.pixel_y);
            end
            S_M1: begin
                w_req.start = !r_wait;
                w_a = mbe_pkg::mag64(w_sum);
                w_b = mbe_pkg::mag64(w_diff);
            end
            S_M2: begin
                w_req.start = !r_wait;
                w_a = mbe_pkg::mag64(r_zr);
                w_b = mbe_pkg::mag64(r_zi);
            end
            S_N1: begin
                w_req.start = !r_wait;
                w_a = mbe_pkg::mag64(r_zr);
                w_b = w_a;
            end
            S_N2: begin
                w_req.start = !r_wait;
                w_a = mbe_pkg::mag64(r_zi);
                w_b = w_a;
            end
            default: ;
        endcase
    end

    mbe_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    assign w_prod = mbe_pkg::fx_sign(w_mul_res, r_zr[63] ^ r_zi[63]);
    assign w_nsum = {1'b0, r_p} + {1'b0, w_mul_res};

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_loop   = (r_count < r_max_iter) &&
                      (r_norm < mbe_pkg::NORM_BITS'(r_esc_limit));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_wait <= 1'b1;
            end
            if (r_wait && w_mul_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pix         <= i_in_data;
                        r_zr          <= '0;
                        r_zi          <= '0;
                        r_norm        <= '0;
                        r_count       <= '0;
                        r_extra_phase <= 1'b0;
                        r_extra       <= '0;
                        r_state       <= S_CX;
                    end
                end
                S_CX: begin
                    if (r_wait && w_mul_done) begin
                        r_cr <= mbe_pkg::sat_add(mbe_pkg::fx_sign(w_mul_res, r_scale_x[31]),
                                                 64'(r_offset_x));
                        r_state <= S_CY;
                    end
                end
                S_CY: begin
                    if (r_wait && w_mul_done) begin
                        r_ci <= mbe_pkg::sat_add(mbe_pkg::fx_sign(w_mul_res, r_scale_y[31]),
                                                 64'(r_offset_y));
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_loop) begin
                        r_extra_phase <= 1'b1;
                    end
                    r_state <= S_M1;
                end
                S_M1: begin
                    if (r_wait && w_mul_done) begin
                        r_t <= mbe_pkg::sat_add(
                            mbe_pkg::fx_sign(w_mul_res, w_sum[63] ^ w_diff[63]), r_cr);
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (r_wait && w_mul_done) begin
                        r_zr <= r_t;
                        r_zi <= mbe_pkg::sat_add(mbe_pkg::sat_add(w_prod, w_prod), r_ci);
                        if (!r_extra_phase) begin
                            r_count <= r_count + 1'b1;
                            r_state <= S_N1;
                        end else begin
                            r_extra <= r_extra + 1'b1;
                            if (r_extra == mbe_pkg::EXTRA_BITS'(mbe_pkg::EXTRA_STEPS - 1)) begin
                                r_state <= S_N1;
                            end else begin
                                r_state <= S_M1;
                            end
                        end
                    end
                end
                S_N1: begin
                    if (r_wait && w_mul_done) begin
                        r_p     <= w_mul_res;
                        r_state <= S_N2;
                    end
                end
                S_N2: begin
                    if (r_wait && w_mul_done) begin
                        r_norm  <= w_nsum[63] ? '1 : w_nsum[mbe_pkg::NORM_BITS-1:0];
                        r_state <= r_extra_phase ? S_DONE : S_CHECK;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data.iteration_count <= r_count;
                        r_out_data.final_norm      <= r_norm;
                        r_out_valid                <= 1'b1;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CX))
        else $error("accepted transaction did not start setup");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_wait)
        else $error("multiplier result with no request outstanding");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion");

    a_check_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> !r_extra_phase)
        else $error("escape check reached during extra steps");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> (r_count <= r_max_iter))
        else $error("step count passed the iteration bound");

endmodule

// File: rtl/mbe_mul.sv
// mbe_mul: sequential 64x64 unsigned multiplier on one 32x32 unit,
// product shifted by the fraction width and saturated unless raw is requested; uses mbe_pkg
module mbe_mul #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbe_pkg::t_mul_req              i_req,
    input  logic [63:0]                    i_a,
    input  logic [63:0]                    i_b,
    output logic                           o_done,
    output logic [mbe_pkg::NORM_BITS-1:0]  o_res
);

    localparam logic [2:0] LAST_MUL  = 3'd3;
    localparam logic [2:0] LAST_ACC  = 3'd4;
    localparam logic [2:0] SAT_STEP  = 3'd5;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_raw;
    logic         r_run;
    logic [2:0]   r_step;
    logic [63:0]  r_prod;
    logic [127:0] r_acc;
    logic         r_done;
    logic [mbe_pkg::NORM_BITS-1:0] r_res;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_mul;
    logic [1:0]   w_pidx;
    logic [6:0]   w_sh;
    logic [127:0] w_part;
    logic [mbe_pkg::NORM_BITS-1:0] w_sat;

    assign w_ah  = r_step[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh  = r_step[0] ? r_b[63:32] : r_b[31:0];
    assign w_mul = w_ah * w_bh;

    assign w_pidx = r_step[1:0] - 2'd1;

    always_comb begin
        case (w_pidx)
            2'd0:    w_sh = 7'd0;
            2'd3:    w_sh = 7'd64;
            default: w_sh = 7'd32;
        endcase
    end

    assign w_part = {64'd0, r_prod} << w_sh;

    always_comb begin
        if (r_raw) begin
            w_sat = r_acc[mbe_pkg::NORM_BITS-1:0];
        end else if (|r_acc[127:63+FRAC_BITS]) begin
            w_sat = '1;
        end else begin
            w_sat = r_acc[62+FRAC_BITS:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_req.start && r_run && (r_step == SAT_STEP);
            if (i_req.start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_raw  <= i_req.raw;
                r_run  <= 1'b1;
                r_step <= '0;
                r_acc  <= '0;
            end else if (r_run) begin
                if (r_step <= LAST_MUL) begin
                    r_prod <= w_mul;
                end
                if (r_step != 3'd0 && r_step <= LAST_ACC) begin
                    r_acc <= r_acc + w_part;
                end
                if (r_step == SAT_STEP) begin
                    r_res  <= w_sat;
                    r_run  <= 1'b0;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: tb/tb_mandelbrot_escape_time.sv
`timescale 1ns / 100ps
// tb_mandelbrot_escape_time: self-checking bench for the escape time engine
// predicts every pixel result in saturating fixed point and checks each output
// transaction; depends on mbe_pkg and mandelbrot_escape_time
module tb_mandelbrot_escape_time;

    typedef logic signed [63:0] t_fix;

    localparam logic [mbe_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [mbe_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;
    localparam logic signed [64:0] SUM_HI = {1'b0, mbe_pkg::SAT_MAX};

    localparam logic [31:0] LIMIT_FOUR = 32'h4000_0000;
    localparam logic [31:0] REAL_THREE = 32'h3000_0000;
    localparam logic [31:0] REAL_MINUS_ONE = 32'hF000_0000;
    localparam logic [31:0] VIEW_SX = 32'h0003_0000;
    localparam logic [31:0] VIEW_OX = 32'hDC00_0000;
    localparam logic [31:0] VIEW_SY = 32'hFFFD_0000;
    localparam logic [31:0] VIEW_OY = 32'h1800_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    mbe_pkg::t_pix_in in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    mbe_pkg::t_esc_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mbe_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic idle_on = 1'b0;
    int hold_request = 0;
    int escape_errors = 0;
    mbe_pkg::t_esc_out pending_escapes[$];

    t_fix view_sx;
    t_fix view_ox;
    t_fix view_sy;
    t_fix view_oy;
    logic [mbe_pkg::ITER_BITS-1:0] iter_cap;
    logic [31:0] escape_lim;

    always #5 clk = ~clk;

    mandelbrot_escape_time u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_fix sext_coef(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] fix_abs(input t_fix v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // truncated magnitude product, clipped to the positive maximum
    function automatic logic [63:0] mag_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = ({64'd0, a} * {64'd0, b}) >> mbe_pkg::FRAC_BITS;
        if (wide[127:63] != '0) begin
            return 64'(mbe_pkg::SAT_MAX);
        end
        return wide[63:0];
    endfunction

    function automatic t_fix fix_product(input t_fix a, input t_fix b);
        logic [63:0] m;
        m = mag_product(fix_abs(a), fix_abs(b));
        return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_fix fix_sum(input t_fix a, input t_fix b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SUM_HI) begin
            return mbe_pkg::SAT_MAX;
        end
        if (s < -SUM_HI) begin
            return -mbe_pkg::SAT_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] norm_of(input t_fix zr, input t_fix zi);
        logic [63:0] s;
        s = mag_product(fix_abs(zr), fix_abs(zr)) + mag_product(fix_abs(zi), fix_abs(zi));
        return (s > 64'(mbe_pkg::SAT_MAX)) ? 64'(mbe_pkg::SAT_MAX) : s;
    endfunction

    function automatic void iterate_z(inout t_fix zr, inout t_fix zi,
                                      input t_fix cre, input t_fix cim);
        t_fix cross_term;
        t_fix re_next;
        cross_term = fix_product(zr, zi);
        re_next = fix_sum(fix_product(fix_sum(zr, zi), fix_sum(zr, -zi)), cre);
        zi = fix_sum(fix_sum(cross_term, cross_term), cim);
        zr = re_next;
    endfunction

    function automatic mbe_pkg::t_esc_out predict_escape(input mbe_pkg::t_pix_in pix);
        t_fix px;
        t_fix py;
        t_fix cre;
        t_fix cim;
        t_fix zr;
        t_fix zi;
        logic [63:0] norm;
        int unsigned steps;
        mbe_pkg::t_esc_out res;
        px = {52'd0, pix.pixel_x};
        py = {52'd0, pix.pixel_y};
        cre = fix_sum(view_sx * px, view_ox);
        cim = fix_sum(view_sy * py, view_oy);
        zr = '0;
        zi = '0;
        norm = '0;
        steps = 0;
        while (steps < iter_cap && norm < {32'd0, escape_lim}) begin
            iterate_z(zr, zi, cre, cim);
            norm = norm_of(zr, zi);
            steps++;
        end
        repeat (mbe_pkg::EXTRA_STEPS) iterate_z(zr, zi, cre, cim);
        norm = norm_of(zr, zi);
        res.iteration_count = steps[mbe_pkg::ITER_BITS-1:0];
        res.final_norm = norm[mbe_pkg::NORM_BITS-1:0];
        return res;
    endfunction

    // result checker, one expectation per output transaction
    always @(posedge clk) begin
        mbe_pkg::t_esc_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_escapes.size() == 0) begin
                escape_errors++;
                if (escape_errors <= 10) begin
                    $display("unexpected result: count %0d norm %0h",
                             out_data.iteration_count, out_data.final_norm);
                end
            end else begin
                want = pending_escapes.pop_front();
                if (out_data.iteration_count !== want.iteration_count ||
                    out_data.final_norm !== want.final_norm) begin
                    escape_errors++;
                    if (escape_errors <= 10) begin
                        $display("mismatch: count exp %0d got %0d, norm exp %0h got %0h",
                                 want.iteration_count, out_data.iteration_count,
                                 want.final_norm, out_data.final_norm);
                    end
                end
            end
        end
    end

    // output side stalls: long hold on request, else random bursts while idle_on is set
    initial begin
        forever begin
            if (hold_request > 0) begin
                out_stall = 1'b1;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end else begin
                out_stall = 1'b0;
                @(negedge clk);
            end
        end
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_pixel(input logic [mbe_pkg::PIXEL_BITS-1:0] px,
                              input logic [mbe_pkg::PIXEL_BITS-1:0] py);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_data.pixel_x = px;
        in_data.pixel_y = py;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_escapes.push_back(predict_escape(in_data));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(mbe_pkg::PIXEL_BITS'($urandom_range(0, 4095)),
                                  mbe_pkg::PIXEL_BITS'($urandom_range(0, 4095)));
    endtask

    task automatic wait_drain();
        wait (pending_escapes.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [mbe_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            mbe_pkg::CFG_SCALE_X: view_sx = sext_coef(data);
            mbe_pkg::CFG_OFFSET_X: view_ox = sext_coef(data);
            mbe_pkg::CFG_SCALE_Y: view_sy = sext_coef(data);
            mbe_pkg::CFG_OFFSET_Y: view_oy = sext_coef(data);
            mbe_pkg::CFG_MAX_ITER: iter_cap = data[mbe_pkg::ITER_BITS-1:0];
            mbe_pkg::CFG_ESC_LIMIT: escape_lim = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] sx, input logic [31:0] ox,
                                  input logic [31:0] sy, input logic [31:0] oy,
                                  input logic [mbe_pkg::ITER_BITS-1:0] max_iter,
                                  input logic [31:0] limit);
        wait_drain();
        write_reg(mbe_pkg::CFG_SCALE_X, sx);
        write_reg(mbe_pkg::CFG_OFFSET_X, ox);
        write_reg(mbe_pkg::CFG_SCALE_Y, sy);
        write_reg(mbe_pkg::CFG_OFFSET_Y, oy);
        // upper bits of the iteration register are junk and must be ignored
        write_reg(mbe_pkg::CFG_MAX_ITER, {16'($urandom), max_iter});
        write_reg(mbe_pkg::CFG_ESC_LIMIT, limit);
    endtask

    // jittered view over the whole set, or a wild random mapping
    task automatic pick_random_view(input bit deep);
        logic [mbe_pkg::ITER_BITS-1:0] cap;
        logic [31:0] limit;
        cap = deep ? mbe_pkg::ITER_BITS'(100) : mbe_pkg::ITER_BITS'($urandom_range(1, 16));
        limit = ($urandom_range(0, 2) == 0) ? $urandom : LIMIT_FOUR;
        if ($urandom_range(0, 3) != 0) begin
            apply_settings(VIEW_SX + 32'($urandom_range(0, 131072)) - 32'd65536,
                           VIEW_OX + 32'($urandom_range(0, 8388608)) - 32'd4194304,
                           VIEW_SY + 32'($urandom_range(0, 131072)) - 32'd65536,
                           VIEW_OY + 32'($urandom_range(0, 8388608)) - 32'd4194304,
                           cap, limit);
        end else begin
            apply_settings($urandom, $urandom, $urandom, $urandom,
                           deep ? cap : mbe_pkg::ITER_BITS'($urandom_range(0, 16)), $urandom);
        end
    endtask

    task automatic test_reset_view();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        // origin and a nearby point inside the set run to the iteration cap
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd448, 12'd512);
    endtask

    task automatic test_zero_iterations();
        apply_settings(VIEW_SX, VIEW_OX, VIEW_SY, VIEW_OY, '0, LIMIT_FOUR);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_zero_limit();
        apply_settings(VIEW_SX, VIEW_OX, VIEW_SY, VIEW_OY, mbe_pkg::ITER_BITS'(100), '0);
        send_pixel(12'd2048, 12'd1024);
        send_pixel(12'd1, 12'd4094);
    endtask

    task automatic test_iteration_ceiling();
        // c near three escapes on the first step even with the widest cap
        apply_settings(32'd1, REAL_THREE, '0, '0, '1, LIMIT_FOUR);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_saturation();
        apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       mbe_pkg::ITER_BITS'(3), 32'hFFFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        apply_settings(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       mbe_pkg::ITER_BITS'(2), 32'hFFFF_FFFF);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2730, 12'd1365);
    endtask

    task automatic test_bounded_orbits();
        apply_settings('0, '0, '0, '0, mbe_pkg::ITER_BITS'(20), 32'hFFFF_FFFF);
        send_pixel(12'd7, 12'd9);
        // c = -1 settles into an orbit that alternates between 0 and -1
        apply_settings('0, REAL_MINUS_ONE, '0, '0, mbe_pkg::ITER_BITS'(20), LIMIT_FOUR);
        send_pixel(12'd100, 12'd200);
    endtask

    task automatic test_spare_indices();
        wait_drain();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        send_pixel(12'd300, 12'd700);
    endtask

    task automatic test_sender_pause();
        pick_random_view(1'b0);
        repeat (2) begin
            send_random_pixels(5);
            wait_drain();
        end
    endtask

    task automatic test_output_backpressure();
        pick_random_view(1'b0);
        hold_request = 2000;
        send_random_pixels(12);
    endtask

    task automatic test_deep_orbits();
        pick_random_view(1'b1);
        send_random_pixels(30);
    endtask

    task automatic test_random_views();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 7) begin
                idle_on = 1'b0;
            end
            pick_random_view(1'b0);
            send_random_pixels(100);
        end
    endtask

    initial begin
        view_sx = sext_coef(mbe_pkg::RST_SCALE_X);
        view_ox = sext_coef(mbe_pkg::RST_OFFSET_X);
        view_sy = sext_coef(mbe_pkg::RST_SCALE_Y);
        view_oy = sext_coef(mbe_pkg::RST_OFFSET_Y);
        iter_cap = mbe_pkg::RST_MAX_ITER;
        escape_lim = mbe_pkg::RST_ESC_LIM;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_view();
        test_zero_iterations();
        test_zero_limit();
        test_iteration_ceiling();
        test_saturation();
        test_bounded_orbits();
        test_spare_indices();

        idle_on = 1'b1;
        test_sender_pause();
        test_output_backpressure();
        test_deep_orbits();
        test_random_views();

        wait_drain();
        repeat (500) @(posedge clk);
        if (escape_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mandelbrot_escape_time.sv
tb/tb_mandelbrot_escape_time.sv
